[rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define GSM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gsm assertion failed");

// Next-cycle implication, disabled while reset is low
`define GSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gsm assertion failed");

`endif

[rtl/gsm_pkg.sv]
package gsm_pkg;

  // Default sizes
  localparam int STACK_DEPTH_DEF = 256;
  localparam int SLOT_COUNT_DEF  = 256;

  // Register port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int N_OPS  = 6;

  // Instruction codes
  localparam logic [2:0] CMD_NOP    = 3'd0;
  localparam logic [2:0] CMD_CONST  = 3'd1;
  localparam logic [2:0] CMD_ADD    = 3'd2;
  localparam logic [2:0] CMD_LOAD   = 3'd3;
  localparam logic [2:0] CMD_STORE  = 3'd4;
  localparam logic [2:0] CMD_RETURN = 3'd5;
  localparam logic [2:0] CMD_BEGIN  = 3'd6;
  localparam logic [2:0] CMD_END    = 3'd7;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SUCCESS = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_UNDER   = 3'd3;
  localparam logic [2:0] ST_GAS     = 3'd4;
  localparam logic [2:0] ST_KEY     = 3'd5;
  localparam logic [2:0] ST_IGNORED = 3'd6;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_COST_NOP    = 3'd0;
  localparam logic [2:0] REG_COST_CONST  = 3'd1;
  localparam logic [2:0] REG_COST_ADD    = 3'd2;
  localparam logic [2:0] REG_COST_LOAD   = 3'd3;
  localparam logic [2:0] REG_COST_STORE  = 3'd4;
  localparam logic [2:0] REG_COST_RETURN = 3'd5;
  localparam logic [2:0] REG_BYTE_COST   = 3'd6;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [63:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        done_res;
    logic [31:0] value;
    logic [31:0] gas_total;
    logic [31:0] store_total;
  } out_item_t;

  typedef struct packed {
    logic [N_OPS-1:0][15:0] op_cost;
    logic [7:0]             byte_cost;
  } cost_cfg_t;

  // Machine state kept in flops; tos/nos hold the top two stack entries
  typedef struct packed {
    logic        halted;
    logic [63:0] tos;
    logic [63:0] nos;
    logic [31:0] gas;
    logic [31:0] limit;
    logic [31:0] wcnt;
  } mach_t;

  typedef struct packed {
    logic        stk_we;
    logic [63:0] stk_wdata;
    logic        slot_we;
    logic [31:0] slot_wdata;
  } mem_wr_t;

endpackage

[rtl/gas_metered_stack_machine_unit.sv]
// Channel   Direction  Handshake                 Word
// in_       input      in_valid / in_ready       in_item_t  (cmd, immediate)
// out_      output     out_valid / out_ready     out_item_t (status .. store_total)
// cfg APB   input      psel/penable/pwrite/pready 32-bit registers at 4*index
//
// One word per cycle sustained while out_ready is high; a taken word passes the input
// register, then execute, and its result is loaded into the result register.
// Rate is set by the single execute step: top two stack entries live in flops and the
// third comes from a registered stack memory read addressed with the next stack count.
// After reset the slot memory is zeroed, one entry a cycle, with in_ready low until
// the last entry is cleared. Register writes are taken throughout.
// With out_ready low the result holds and one more word waits in the input register.
module gas_metered_stack_machine_unit import gsm_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int KW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  cost_cfg_t  cost_r;
  logic [2:0] reg_idx;

  logic       s1_valid_r;
  in_item_t   s1_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  mach_t      mach_r;
  logic [CW-1:0] cnt_r;
  logic       clr_busy_r;
  logic [KW-1:0] clr_idx_r;

  logic [63:0] stk_mem [STACK_DEPTH];
  logic [63:0] third_r;
  logic [31:0] slot_mem [SLOT_COUNT];
  logic [31:0] slot_rd_r;
  logic        slot_fwd_r;
  logic [31:0] slot_fwd_data_r;

  logic        in_fire;
  logic        advance;
  logic [KW-1:0] in_key;
  logic [KW-1:0] exe_key;
  logic [31:0] slot_val;
  mach_t       mach_nxt;
  logic [CW-1:0] cnt_nxt;
  logic [CW-1:0] cnt_eff;
  logic [CW-1:0] cnt_m3;
  logic [SAW-1:0] stk_waddr;
  mem_wr_t     wr;
  out_item_t   res;
  logic        slot_we;
  logic [KW-1:0] slot_waddr;
  logic [31:0] slot_wdata;

  // Handshakes
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !clr_busy_r && (!s1_valid_r || advance);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign pready    = 1'b1;
  assign reg_idx   = paddr[CFG_AW-1:2];

  // Register file writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r <= '{op_cost: {N_OPS{16'd1}}, byte_cost: 8'd1};
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_COST_NOP, REG_COST_CONST, REG_COST_ADD,
        REG_COST_LOAD, REG_COST_STORE, REG_COST_RETURN: begin
          cost_r.op_cost[reg_idx] <= pwdata[15:0];
        end
        REG_BYTE_COST: begin
          cost_r.byte_cost <= pwdata[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Register file reads
  always_comb begin
    case (reg_idx)
      REG_COST_NOP, REG_COST_CONST, REG_COST_ADD,
      REG_COST_LOAD, REG_COST_STORE, REG_COST_RETURN: begin
        prdata = {16'b0, cost_r.op_cost[reg_idx]};
      end
      REG_BYTE_COST: begin
        prdata = {24'b0, cost_r.byte_cost};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
    end
  end

  // Execute
  assign slot_val = slot_fwd_r ? slot_fwd_data_r : slot_rd_r;

  gsm_exec #(
    .STACK_DEPTH (STACK_DEPTH),
    .SLOT_COUNT  (SLOT_COUNT)
  ) u_exec (
    .item      (s1_item_r),
    .mach      (mach_r),
    .cnt       (cnt_r),
    .third     (third_r),
    .slot_rd   (slot_val),
    .cost      (cost_r),
    .mach_nxt  (mach_nxt),
    .cnt_nxt   (cnt_nxt),
    .stk_waddr (stk_waddr),
    .wr        (wr),
    .res       (res)
  );

  // Machine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mach_r <= '{halted: 1'b1, default: '0};
      cnt_r  <= '0;
    end else if (advance) begin
      mach_r <= mach_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res;
    end
  end

  // Stack memory: write-through of every push, prefetch of the third entry
  assign cnt_eff = advance ? cnt_nxt : cnt_r;
  assign cnt_m3  = cnt_eff - CW'(3);

  always_ff @(posedge clk) begin
    if (advance && wr.stk_we) begin
      stk_mem[stk_waddr] <= wr.stk_wdata;
    end
    third_r <= stk_mem[cnt_m3[SAW-1:0]];
  end

  // Slot memory clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + KW'(1);
      if (clr_idx_r == KW'(SLOT_COUNT - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign in_key  = in_data.immediate[KW-1:0];
  assign exe_key = s1_item_r.immediate[KW-1:0];

  always_comb begin
    if (clr_busy_r) begin
      slot_we    = 1'b1;
      slot_waddr = clr_idx_r;
      slot_wdata = '0;
    end else begin
      slot_we    = advance && wr.slot_we;
      slot_waddr = exe_key;
      slot_wdata = wr.slot_wdata;
    end
  end

  // Slot memory: read at accept, forward a store from the word ahead
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (in_fire) begin
      slot_rd_r       <= slot_mem[in_key];
      slot_fwd_r      <= advance && wr.slot_we && (exe_key == in_key);
      slot_fwd_data_r <= wr.slot_wdata;
    end
  end

endmodule

[rtl/gsm_exec.sv]
// Executes one instruction against the current machine state.
module gsm_exec import gsm_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
  localparam int CW  = $clog2(STACK_DEPTH + 1),
  localparam int SAW = $clog2(STACK_DEPTH)
) (
  input  in_item_t  item,
  input  mach_t     mach,
  input  logic [CW-1:0] cnt,
  input  logic [63:0] third,
  input  logic [31:0] slot_rd,
  input  cost_cfg_t cost,
  output mach_t     mach_nxt,
  output logic [CW-1:0] cnt_nxt,
  output logic [SAW-1:0] stk_waddr,
  output mem_wr_t   wr,
  output out_item_t res
);

  logic [15:0] op_cost;
  logic [32:0] gas_op;
  logic        ok_op;
  logic [10:0] mem_chg;
  logic [33:0] gas_mem;
  logic        ok_mem;
  logic        full;
  logic        key_ok;
  logic [63:0] sum;
  logic [63:0] push_val;
  logic [31:0] lim_sat;
  logic [CW-1:0] cnt_m2;
  logic [2:0]  status;
  logic [31:0] value;
  logic        done;

  // Gas checks: instruction cost, then memory bytes on top of it
  always_comb begin
    if (item.cmd <= CMD_RETURN) begin
      op_cost = cost.op_cost[item.cmd];
    end else begin
      op_cost = '0;
    end
    gas_op  = {1'b0, mach.gas} + {17'b0, op_cost};
    ok_op   = gas_op <= {1'b0, mach.limit};
    // store moves 4 bytes, a push 8
    if (item.cmd == CMD_STORE) begin
      mem_chg = {1'b0, cost.byte_cost, 2'b00};
    end else begin
      mem_chg = {cost.byte_cost, 3'b000};
    end
    gas_mem = {1'b0, gas_op} + {23'b0, mem_chg};
    ok_mem  = gas_mem <= {2'b0, mach.limit};
  end

  // Operand checks and data paths
  always_comb begin
    full     = cnt == CW'(STACK_DEPTH);
    key_ok   = $unsigned(item.immediate) < 64'(SLOT_COUNT);
    sum      = mach.tos + mach.nos;
    cnt_m2   = cnt - CW'(2);
    push_val = (item.cmd == CMD_LOAD) ? {32'b0, slot_rd} : item.immediate;
    // begin limit saturates to 0..2^32-1
    if (item.immediate[63]) begin
      lim_sat = '0;
    end else if (|item.immediate[62:32]) begin
      lim_sat = '1;
    end else begin
      lim_sat = item.immediate[31:0];
    end
  end

  // Instruction sequencing
  always_comb begin
    mach_nxt  = mach;
    cnt_nxt   = cnt;
    stk_waddr = cnt[SAW-1:0];
    wr        = '0;
    status    = ST_OK;
    value     = '0;

    if (item.cmd == CMD_BEGIN) begin
      mach_nxt.halted = 1'b0;
      mach_nxt.gas    = '0;
      mach_nxt.wcnt   = '0;
      mach_nxt.limit  = lim_sat;
      cnt_nxt         = '0;
    end else if (mach.halted) begin
      status = ST_IGNORED;
    end else if (item.cmd == CMD_END) begin
      status = ST_SUCCESS;
    end else if (!ok_op) begin
      status = ST_GAS;
    end else begin
      mach_nxt.gas = gas_op[31:0];
      case (item.cmd)
        CMD_CONST, CMD_LOAD: begin
          if (item.cmd == CMD_LOAD && !key_ok) begin
            status = ST_KEY;
          end else if (full) begin
            status = ST_FULL;
          end else if (!ok_mem) begin
            status = ST_GAS;
          end else begin
            mach_nxt.gas = gas_mem[31:0];
            mach_nxt.tos = push_val;
            mach_nxt.nos = mach.tos;
            cnt_nxt      = cnt + CW'(1);
            wr.stk_we    = 1'b1;
            wr.stk_wdata = push_val;
          end
        end
        CMD_ADD: begin
          if (cnt < CW'(2)) begin
            status = ST_UNDER;
          end else if (!ok_mem) begin
            status = ST_GAS;
          end else begin
            // pop two, push the sum in place of the lower one
            mach_nxt.gas = gas_mem[31:0];
            mach_nxt.tos = sum;
            mach_nxt.nos = third;
            cnt_nxt      = cnt - CW'(1);
            stk_waddr    = cnt_m2[SAW-1:0];
            wr.stk_we    = 1'b1;
            wr.stk_wdata = sum;
          end
        end
        CMD_STORE: begin
          if (cnt == '0) begin
            status = ST_UNDER;
          end else if (!key_ok) begin
            status = ST_KEY;
          end else if (!ok_mem) begin
            status = ST_GAS;
          end else begin
            mach_nxt.gas  = gas_mem[31:0];
            mach_nxt.wcnt = mach.wcnt + 32'd1;
            mach_nxt.tos  = mach.nos;
            mach_nxt.nos  = third;
            cnt_nxt       = cnt - CW'(1);
            wr.slot_we    = 1'b1;
            wr.slot_wdata = mach.tos[31:0];
          end
        end
        CMD_RETURN: begin
          if (cnt == '0) begin
            status = ST_UNDER;
          end else begin
            status = ST_SUCCESS;
            value  = mach.tos[31:0];
          end
        end
        default: begin
        end
      endcase
    end

    // any error, return or end closes the request
    done = (item.cmd != CMD_BEGIN) && (status != ST_OK) && (status != ST_IGNORED);
    if (done) begin
      mach_nxt.halted = 1'b1;
    end

    res.status      = status;
    res.done_res    = done;
    res.value       = value;
    res.gas_total   = mach_nxt.gas;
    res.store_total = mach_nxt.wcnt;
  end

endmodule

[rtl/gsm_checker.sv]
`include "assert_macros.svh"

// Port-level checks on the stack machine unit.
module gsm_checker import gsm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input out_item_t         out_data,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [CFG_AW-1:0] paddr,
  input logic [CFG_DW-1:0] pwdata,
  input logic [CFG_DW-1:0] prdata,
  input logic              pready
);

  logic              in_fire;
  logic              out_free;
  logic              cfg_wr_nop;
  logic              cfg_rd_nop;
  logic [CFG_DW-1:0] nop_cost_ext;

  // Handshake and register port shorthands
  assign in_fire      = in_valid && in_ready;
  assign out_free     = !out_valid || out_ready;
  assign cfg_wr_nop   = psel && penable && pwrite && pready &&
                        (paddr[CFG_AW-1:2] == REG_COST_NOP);
  assign cfg_rd_nop   = psel && !pwrite && (paddr[CFG_AW-1:2] == REG_COST_NOP);
  assign nop_cost_ext = {16'b0, pwdata[15:0]};

  // stalled result word holds
  `GSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // an accepted word reaches the result register as soon as it is free
  `GSM_ASSERT_NEXT(a_in_to_out, in_fire ##1 out_free, out_valid)

  // input side never blocks while the result side stays empty
  `GSM_ASSERT_IMPL(a_no_block, (in_ready && !out_valid) ##1 !out_valid, in_ready)

  // the NOP cost register reads back what was written
  `GSM_ASSERT_IMPL(a_cfg_readback, cfg_wr_nop ##1 cfg_rd_nop, prdata == $past(nop_cost_ext))

endmodule

bind gas_metered_stack_machine_unit gsm_checker u_gsm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);

[dv/tb_gas_metered_stack_machine_unit.sv]
module tb_gas_metered_stack_machine_unit;
  import gsm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int WORDS_PER_PHASE = 100;
  localparam int LONG_HOLD = 300;

  // Cost register list, in register order
  localparam logic [2:0] COST_REGS [7] = '{REG_COST_NOP, REG_COST_CONST, REG_COST_ADD,
                                            REG_COST_LOAD, REG_COST_STORE, REG_COST_RETURN,
                                            REG_BYTE_COST};

  typedef enum {COSTS_ZERO, COSTS_MAX, COSTS_WIDE, COSTS_TIGHT} cost_plan_t;

  // Machine predictor plus the queue of results it has worked out
  class gsm_scoreboard;
    localparam logic [63:0] PUSH_BYTES  = 64'd8;
    localparam logic [63:0] STORE_BYTES = 64'd4;

    logic [63:0] opstack [STACK_DEPTH_DEF];
    int unsigned depth;
    logic [31:0] slot_data [SLOT_COUNT_DEF];
    bit          slot_written [SLOT_COUNT_DEF];
    logic [31:0] gas_spent;
    logic [31:0] limit_held;
    logic [31:0] store_count;
    bit          halted;
    logic [15:0] op_cost [N_OPS];
    logic [7:0]  byte_cost;

    out_item_t predicted_results[$];
    int sent_words;
    int mismatches;

    function new();
      depth = 0;
      gas_spent = '0;
      limit_held = '0;
      store_count = '0;
      halted = 1'b1;
      for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
        slot_data[i] = '0;
        slot_written[i] = 1'b0;
      end
      for (int i = 0; i < N_OPS; i++) op_cost[i] = 16'd1;
      byte_cost = 8'd1;
      sent_words = 0;
      mismatches = 0;
    endfunction

    function void set_cost(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_COST_NOP:    op_cost[CMD_NOP]    = val[15:0];
        REG_COST_CONST:  op_cost[CMD_CONST]  = val[15:0];
        REG_COST_ADD:    op_cost[CMD_ADD]    = val[15:0];
        REG_COST_LOAD:   op_cost[CMD_LOAD]   = val[15:0];
        REG_COST_STORE:  op_cost[CMD_STORE]  = val[15:0];
        REG_COST_RETURN: op_cost[CMD_RETURN] = val[15:0];
        REG_BYTE_COST:   byte_cost           = val[7:0];
        default: ;
      endcase
    endfunction

    // Charge only if the whole amount fits under the limit
    function bit try_charge(logic [63:0] amount);
      logic [63:0] total;
      total = {32'd0, gas_spent} + amount;
      if (total > {32'd0, limit_held}) return 1'b0;
      gas_spent = total[31:0];
      return 1'b1;
    endfunction

    function logic [2:0] push_operand(logic [63:0] v);
      if (depth >= STACK_DEPTH_DEF) return ST_FULL;
      if (!try_charge({56'd0, byte_cost} * PUSH_BYTES)) return ST_GAS;
      opstack[depth] = v;
      depth++;
      return ST_OK;
    endfunction

    function out_item_t execute_word(in_item_t w);
      out_item_t r;
      logic [63:0] imm;
      logic [63:0] a;
      logic [63:0] b;
      logic [2:0]  st;
      bit          key_good;
      int          k;
      r = '0;
      st = ST_OK;
      imm = w.immediate;
      key_good = imm < 64'(SLOT_COUNT_DEF);
      k = key_good ? int'(imm[31:0]) : 0;
      if (w.cmd == CMD_BEGIN) begin
        depth = 0;
        gas_spent = '0;
        store_count = '0;
        halted = 1'b0;
        // limit saturates to 32 bits, negative means zero
        if (imm[63]) limit_held = '0;
        else if (imm[62:32] != '0) limit_held = '1;
        else limit_held = imm[31:0];
      end else if (halted) begin
        st = ST_IGNORED;
      end else if (w.cmd == CMD_END) begin
        st = ST_SUCCESS;
      end else if (!try_charge({48'd0, op_cost[w.cmd]})) begin
        st = ST_GAS;
      end else begin
        case (w.cmd)
          CMD_CONST: st = push_operand(imm);
          CMD_ADD: begin
            if (depth < 2) begin
              st = ST_UNDER;
            end else begin
              b = opstack[depth-1];
              a = opstack[depth-2];
              depth -= 2;
              st = push_operand(a + b);
            end
          end
          CMD_LOAD: begin
            if (!key_good) st = ST_KEY;
            else st = push_operand(slot_written[k] ? {32'd0, slot_data[k]} : 64'd0);
          end
          CMD_STORE: begin
            if (depth == 0) begin
              st = ST_UNDER;
            end else if (!key_good) begin
              st = ST_KEY;
            end else begin
              a = opstack[depth-1];
              depth--;
              if (!try_charge({56'd0, byte_cost} * STORE_BYTES)) begin
                st = ST_GAS;
              end else begin
                slot_data[k] = a[31:0];
                slot_written[k] = 1'b1;
                store_count++;
              end
            end
          end
          CMD_RETURN: begin
            if (depth == 0) begin
              st = ST_UNDER;
            end else begin
              r.value = opstack[depth-1][31:0];
              st = ST_SUCCESS;
            end
          end
          default: ;
        endcase
      end
      // errors, return and end close the request
      if (w.cmd != CMD_BEGIN && st != ST_OK && st != ST_IGNORED) begin
        r.done_res = 1'b1;
        halted = 1'b1;
      end
      r.status = st;
      r.gas_total = gas_spent;
      r.store_total = store_count;
      return r;
    endfunction

    function void note_word(in_item_t w);
      out_item_t r;
      r = execute_word(w);
      predicted_results.insert(predicted_results.size(), r);
      sent_words++;
    endfunction

    function int outstanding();
      return predicted_results.size();
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: st=%0d done=%0d val=%h gas=%h wr=%0d",
                   got.status, got.done_res, got.value, got.gas_total, got.store_total);
        return;
      end
      exp = predicted_results.pop_front();
      if (got.status !== exp.status || got.done_res !== exp.done_res ||
          got.value !== exp.value || got.gas_total !== exp.gas_total ||
          got.store_total !== exp.store_total) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: st=%0d done=%0d val=%h gas=%h wr=%0d",
                   exp.status, exp.done_res, exp.value, exp.gas_total, exp.store_total);
          $display("         got: st=%0d done=%0d val=%h gas=%h wr=%0d",
                   got.status, got.done_res, got.value, got.gas_total, got.store_total);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  gsm_scoreboard sb = new();
  bit tx_steady;
  bit rx_steady;
  int rx_gap;
  int rx_hold;
  int cycle_count;

  gas_metered_stack_machine_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Result monitor: check each taken word, then draw the next ready gap
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
      rx_gap = rx_steady ? 0 : $urandom_range(0, 5);
    end
  end

  // Receiver: long hold-off first, then per-word gaps
  initial begin
    out_ready = 1'b0;
    rx_gap = 0;
    rx_hold = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ready = 1'b0;
        rx_hold--;
      end else if (rx_gap > 0) begin
        out_ready = 1'b0;
        rx_gap--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t make_word(logic [2:0] cmd, logic [63:0] imm);
    in_item_t w;
    w.cmd = cmd;
    w.immediate = imm;
    return w;
  endfunction

  // Mostly small keys so loads hit earlier stores; some out of range
  function automatic logic [63:0] rand_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 64'($urandom_range(0, 7));
    if (r < 85) return 64'($urandom_range(0, SLOT_COUNT_DEF - 1));
    if (r < 92) return 64'(SLOT_COUNT_DEF + $urandom_range(0, 1000));
    return rand64();
  endfunction

  function automatic logic [63:0] rand_limit();
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 60));
      1: return 64'($urandom_range(0, 5000));
      2: return {32'd0, $urandom};
      3: return 64'hFFFF_FFFF;
      4: return {$urandom | 32'h8000_0000, $urandom};
      default: return {32'($urandom_range(1, 32'h7FFF_FFFF)), $urandom};
    endcase
  endfunction

  function automatic in_item_t rand_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return make_word(CMD_CONST, rand64());
    if (r < 45) return make_word(CMD_ADD, rand64());
    if (r < 60) return make_word(CMD_LOAD, rand_key());
    if (r < 75) return make_word(CMD_STORE, rand_key());
    if (r < 83) return make_word(CMD_NOP, rand64());
    if (r < 88) return make_word(CMD_RETURN, rand64());
    return make_word(3'($urandom_range(0, 7)), rand64());
  endfunction

  // Offer one word after a random gap; valid stays up when the gap is zero
  task automatic send_word(input in_item_t w);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
    @(negedge clk);
  endtask

  // Stop offering and wait for every predicted result
  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_cost(idx, val);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic program_costs(input cost_plan_t plan);
    logic [31:0] v;
    for (int i = 0; i < 7; i++) begin
      case (plan)
        COSTS_ZERO:  v = '0;
        COSTS_MAX:   v = '1;
        COSTS_WIDE:  v = $urandom;
        default:     v = $urandom_range(0, 3);
      endcase
      write_reg(COST_REGS[i], v);
    end
  endtask

  // Edge cases at reset costs
  task automatic run_directed();
    send_word(make_word(CMD_NOP, 64'd0));                      // halted: ignored
    send_word(make_word(CMD_BEGIN, 64'hFFFF_FFFF_FFFF_FFFF));  // negative limit -> 0
    send_word(make_word(CMD_NOP, 64'd0));                      // out of gas
    send_word(make_word(CMD_BEGIN, 64'h7FFF_FFFF_FFFF_FFFF));  // saturates
    send_word(make_word(CMD_CONST, 64'h8000_0000_0000_0001));
    send_word(make_word(CMD_CONST, 64'hFFFF_FFFF_FFFF_FFFF));
    send_word(make_word(CMD_ADD, 64'd0));                      // wraps
    send_word(make_word(CMD_STORE, 64'd0));
    send_word(make_word(CMD_LOAD, 64'd0));
    send_word(make_word(CMD_LOAD, 64'(SLOT_COUNT_DEF)));       // bad key
    send_word(make_word(CMD_BEGIN, 64'd13));
    send_word(make_word(CMD_CONST, 64'hDEAD_BEEF_1234_5678));
    send_word(make_word(CMD_STORE, 64'(SLOT_COUNT_DEF - 1)));  // store byte charge fails
    send_word(make_word(CMD_BEGIN, 64'h1_0000_0000));
    send_word(make_word(CMD_ADD, 64'd0));                      // underflow
    send_word(make_word(CMD_BEGIN, 64'd100));
    send_word(make_word(CMD_STORE, 64'd3));                    // underflow
    send_word(make_word(CMD_BEGIN, 64'd100));
    send_word(make_word(CMD_CONST, 64'd5));
    send_word(make_word(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFF));  // negative key
    send_word(make_word(CMD_BEGIN, 64'd100));
    send_word(make_word(CMD_CONST, 64'd7));
    send_word(make_word(CMD_BEGIN, 64'd100));                  // restart mid-request
    send_word(make_word(CMD_RETURN, 64'd0));                   // empty again
    send_word(make_word(CMD_BEGIN, 64'd100));
    send_word(make_word(CMD_END, 64'd0));
    send_word(make_word(CMD_RETURN, 64'd0));                   // ignored
  endtask

  // Fill the stack to the top, then one more push, or an add and a return
  task automatic fill_stack();
    send_word(make_word(CMD_BEGIN, 64'hFFFF_FFFF));
    repeat (STACK_DEPTH_DEF) send_word(make_word(CMD_CONST, rand64()));
    case ($urandom_range(0, 2))
      0: send_word(make_word(CMD_CONST, rand64()));
      1: send_word(make_word(CMD_LOAD, 64'($urandom_range(0, SLOT_COUNT_DEF - 1))));
      default: begin
        send_word(make_word(CMD_ADD, 64'd0));
        send_word(make_word(CMD_RETURN, 64'd0));
      end
    endcase
  endtask

  // One request: sometimes stray words first, then begin, one to twelve ops, then end, return or nothing
  task automatic run_request();
    int n;
    int r;
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) send_word(make_word(3'($urandom_range(0, 7)), rand64()));
    send_word(make_word(CMD_BEGIN, rand_limit()));
    n = $urandom_range(1, 12);
    repeat (n) send_word(rand_op());
    r = $urandom_range(0, 9);
    if (r < 5) send_word(make_word(CMD_END, rand64()));
    else if (r < 8) send_word(make_word(CMD_RETURN, rand64()));
  endtask

  // Optional stack fill, then random requests until the phase's word count is sent, then wait for idle
  task automatic run_phase(input int quota, input bit deep);
    int goal;
    if (deep) fill_stack();
    goal = sb.sent_words + quota;
    while (sb.sent_words < goal) begin
      run_request();
      if ($urandom_range(0, 19) == 0) tx_steady = !tx_steady;
      if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
    end
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset costs
    run_directed();
    run_phase(WORDS_PER_PHASE, 1'b1);

    program_costs(COSTS_ZERO);
    run_phase(WORDS_PER_PHASE, 1'b0);

    // top costs, with the receiver stalled long enough to back up the input
    program_costs(COSTS_MAX);
    rx_hold = LONG_HOLD;
    run_phase(WORDS_PER_PHASE, 1'b0);

    program_costs(COSTS_TIGHT);
    run_phase(WORDS_PER_PHASE, 1'b0);

    program_costs(COSTS_WIDE);
    run_phase(WORDS_PER_PHASE, 1'b0);

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
